### rtl/core/bipartite_max_matching_top_macros.svh
// Assertion macros shared by the matching block.
// Included by the top level, which carries the concurrent checks.
`ifndef BIPARTITE_MAX_MATCHING_TOP_MACROS_SVH
`define BIPARTITE_MAX_MATCHING_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bmm_pkg.sv
// Package for the bipartite matching block: action codes, register indexes,
// the field width and the sequencer state type. No dependencies.
package bmm_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_RUN    = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic REG_LEFT_COUNT  = 1'b0;
    localparam logic REG_RIGHT_COUNT = 1'b1;

    localparam int FIELD_W = 10;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR,
        ST_RSWEEP,
        ST_START,
        ST_HEAD,
        ST_EDGE,
        ST_TGT,
        ST_VIS,
        ST_POP,
        ST_UNWIND,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage

### rtl/core/bmm_if.sv
// Channel interfaces of the matching block: command items in, result items out.
// Depends on bmm_pkg for the field width.
interface bmm_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [bmm_pkg::FIELD_W-1:0]   left_vertex;
    logic [bmm_pkg::FIELD_W-1:0]   right_vertex;
    modport source (output valid, action, left_vertex, right_vertex, input ready);
    modport sink (input valid, action, left_vertex, right_vertex, output ready);
endinterface

interface bmm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bmm_pkg::FIELD_W-1:0]   match_count;
    logic                          edges_dropped;
    modport source (output valid, match_count, edges_dropped, input ready);
    modport sink (input valid, match_count, edges_dropped, output ready);
endinterface

### rtl/core/bipartite_max_matching_top.sv
// Top level of the bipartite matching block: command decode, list heads,
// match table, search stack and the search sequencer.
// Depends on bmm_pkg, bmm_if, bmm_edge_store and the assertion macro header.
//
//  channel | dir | payload                                 | handshake
//  cmd     | in  | action, left_vertex, right_vertex       | valid/ready
//  rsp     | out | match_count, edges_dropped              | valid/ready
//  wr      | in  | wr_index, wr_data                       | wr_en, no wait
//
// An add item reads the list head, then writes the edge and new head; a clear
// sweeps the list heads, and so does the sweep after reset. A run first sweeps
// the match table clear. Each left vertex then goes through START and HEAD, each
// edge tried through EDGE, TGT and VIS (VIS skipped if its target is out of
// range), a push back to HEAD, a pop through EDGE and POP, each unwound level
// through UNWIND; a search ends in NEXT. Memories have one write and one registered
// read port. Results wait in an output register; DONE stalls while it is full.
`include "bipartite_max_matching_top_macros.svh"

module bipartite_max_matching_top #(
    parameter int MAX_VERTICES = 512,
    parameter int MAX_EDGES    = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bmm_cmd_if.sink                     cmd,
    bmm_rsp_if.source                   rsp,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [bmm_pkg::FIELD_W-1:0] wr_data
);

    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int PW  = $clog2(MAX_EDGES + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int SAW = $clog2(MAX_VERTICES + 1);
    localparam int SW  = $clog2(MAX_VERTICES + 2);
    localparam int NW  = (VW > bmm_pkg::FIELD_W) ? VW : bmm_pkg::FIELD_W;
    localparam int FW  = VW + PW + VW;
    localparam int RW  = VW + VW;

    localparam logic [NW-1:0] V_N  = NW'(MAX_VERTICES);
    localparam logic [PW-1:0] E_P  = PW'(MAX_EDGES);
    localparam logic [IW-1:0] LAST = IW'(MAX_VERTICES - 1);
    localparam logic [SW-1:0] SP_MAX = SW'(MAX_VERTICES + 1);

    bmm_pkg::state_t state_reg, state_next;

    logic [bmm_pkg::FIELD_W-1:0] left_count_reg, right_count_reg;
    logic [PW-1:0] total_reg, total_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] sweep_reg, sweep_next;
    logic [VW-1:0] i_reg, i_next;
    logic [VW-1:0] count_reg, count_next;
    logic [VW-1:0] cur_left_reg, cur_left_next;
    logic [PW-1:0] cursor_reg, cursor_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [VW-1:0] t_reg, t_next;
    logic [IW-1:0] add_u_reg, add_u_next;
    logic [VW-1:0] add_v_reg, add_v_next;
    logic          out_valid_reg, out_valid_next;
    logic [bmm_pkg::FIELD_W-1:0] out_count_reg, out_count_next;
    logic          out_drop_reg, out_drop_next;

    logic [PW-1:0] head_mem [MAX_VERTICES];
    logic [RW-1:0] rmem [MAX_VERTICES];
    logic [FW-1:0] stack_mem [MAX_VERTICES + 1];

    logic          head_we;
    logic [IW-1:0] head_waddr, head_raddr;
    logic [PW-1:0] head_wdata, head_rdata_reg;
    logic          rm_we;
    logic [IW-1:0] rm_waddr, rm_raddr;
    logic [RW-1:0] rm_wdata, rm_rdata_reg;
    logic          st_we;
    logic [SAW-1:0] st_waddr, st_raddr;
    logic [FW-1:0] st_wdata, st_rdata_reg;

    logic          es_we;
    logic [EW-1:0] es_waddr, es_raddr;
    logic [VW-1:0] es_rtarget;
    logic [PW-1:0] es_rnext;

    logic [VW-1:0] nl, nr;
    logic [NW-1:0] u_n, v_n;
    logic [VW-1:0] rm_tag, rm_partner;
    logic [VW-1:0] fr_left, fr_right;
    logic [PW-1:0] fr_cursor;

    assign nl = (NW'(left_count_reg) > V_N) ? VW'(MAX_VERTICES) : VW'(left_count_reg);
    assign nr = (NW'(right_count_reg) > V_N) ? VW'(MAX_VERTICES) : VW'(right_count_reg);
    assign u_n = NW'(cmd.left_vertex);
    assign v_n = NW'(cmd.right_vertex);
    assign rm_tag     = rm_rdata_reg[RW-1:VW];
    assign rm_partner = rm_rdata_reg[VW-1:0];
    assign fr_left    = st_rdata_reg[FW-1:PW+VW];
    assign fr_cursor  = st_rdata_reg[PW+VW-1:VW];
    assign fr_right   = st_rdata_reg[VW-1:0];

    assign cmd.ready         = (state_reg == bmm_pkg::ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.match_count   = out_count_reg;
    assign rsp.edges_dropped = out_drop_reg;

    bmm_edge_store #(
        .DEPTH (MAX_EDGES),
        .AW    (EW),
        .TW    (VW),
        .NW    (PW)
    ) u_edge_store (
        .clk     (clk),
        .we      (es_we),
        .waddr   (es_waddr),
        .wtarget (add_v_reg),
        .wnext   (head_rdata_reg),
        .raddr   (es_raddr),
        .rtarget (es_rtarget),
        .rnext   (es_rnext)
    );

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rdata_reg <= head_mem[head_raddr];
        if (rm_we)
        begin
            rmem[rm_waddr] <= rm_wdata;
        end
        rm_rdata_reg <= rmem[rm_raddr];
        if (st_we)
        begin
            stack_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= stack_mem[st_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bmm_pkg::ST_CLEAR;
            left_count_reg  <= bmm_pkg::FIELD_W'(1);
            right_count_reg <= bmm_pkg::FIELD_W'(1);
            total_reg       <= '0;
            ovf_reg         <= 1'b0;
            sweep_reg       <= '0;
            sp_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            sweep_reg     <= sweep_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    bmm_pkg::REG_LEFT_COUNT:  left_count_reg  <= wr_data;
                    bmm_pkg::REG_RIGHT_COUNT: right_count_reg <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        count_reg     <= count_next;
        cur_left_reg  <= cur_left_next;
        cursor_reg    <= cursor_next;
        t_reg         <= t_next;
        add_u_reg     <= add_u_next;
        add_v_reg     <= add_v_next;
        out_count_reg <= out_count_next;
        out_drop_reg  <= out_drop_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        sweep_next     = sweep_reg;
        i_next         = i_reg;
        count_next     = count_reg;
        cur_left_next  = cur_left_reg;
        cursor_next    = cursor_reg;
        sp_next        = sp_reg;
        t_next         = t_reg;
        add_u_next     = add_u_reg;
        add_v_next     = add_v_reg;
        out_count_next = out_count_reg;
        out_drop_next  = out_drop_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        head_we    = 1'b0;
        head_waddr = sweep_reg;
        head_wdata = '0;
        head_raddr = '0;
        rm_we      = 1'b0;
        rm_waddr   = sweep_reg;
        rm_wdata   = '0;
        rm_raddr   = '0;
        st_we      = 1'b0;
        st_waddr   = sp_reg[SAW-1:0];
        st_wdata   = {cur_left_reg, cursor_reg, t_reg};
        st_raddr   = '0;
        es_we      = 1'b0;
        es_waddr   = total_reg[EW-1:0];
        es_raddr   = '0;

        unique case (state_reg)
            bmm_pkg::ST_CLEAR:
            begin
                head_we    = 1'b1;
                sweep_next = sweep_reg + IW'(1);
                if (sweep_reg == LAST)
                begin
                    sweep_next = '0;
                    state_next = bmm_pkg::ST_IDLE;
                end
            end
            bmm_pkg::ST_IDLE:
            begin
                add_u_next = IW'(u_n - NW'(1));
                add_v_next = VW'(v_n);
                head_raddr = IW'(u_n - NW'(1));
                if (cmd.valid)
                begin
                    unique case (cmd.action)
                        bmm_pkg::ACT_ADD:
                        begin
                            if (u_n != '0 && u_n <= V_N && v_n != '0 && v_n <= V_N)
                            begin
                                if (total_reg == E_P)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = bmm_pkg::ST_ADD_WR;
                                end
                            end
                        end
                        bmm_pkg::ACT_RUN:
                        begin
                            sweep_next = '0;
                            state_next = bmm_pkg::ST_RSWEEP;
                        end
                        bmm_pkg::ACT_CLEAR:
                        begin
                            total_next = '0;
                            ovf_next   = 1'b0;
                            sweep_next = '0;
                            state_next = bmm_pkg::ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            bmm_pkg::ST_ADD_WR:
            begin
                es_we      = 1'b1;
                head_we    = 1'b1;
                head_waddr = add_u_reg;
                head_wdata = total_reg + PW'(1);
                total_next = total_reg + PW'(1);
                state_next = bmm_pkg::ST_IDLE;
            end
            bmm_pkg::ST_RSWEEP:
            begin
                rm_we      = 1'b1;
                sweep_next = sweep_reg + IW'(1);
                if (sweep_reg == LAST)
                begin
                    sweep_next = '0;
                    i_next     = VW'(1);
                    count_next = '0;
                    state_next = (nl == '0) ? bmm_pkg::ST_DONE : bmm_pkg::ST_START;
                end
            end
            bmm_pkg::ST_START:
            begin
                head_raddr    = IW'(i_reg - VW'(1));
                cur_left_next = i_reg;
                sp_next       = '0;
                state_next    = bmm_pkg::ST_HEAD;
            end
            bmm_pkg::ST_HEAD:
            begin
                cursor_next = head_rdata_reg;
                state_next  = bmm_pkg::ST_EDGE;
            end
            bmm_pkg::ST_EDGE:
            begin
                es_raddr = EW'(cursor_reg - PW'(1));
                st_raddr = SAW'(sp_reg - SW'(1));
                if (cursor_reg == '0)
                begin
                    state_next = (sp_reg == '0) ? bmm_pkg::ST_NEXT : bmm_pkg::ST_POP;
                end
                else
                begin
                    state_next = bmm_pkg::ST_TGT;
                end
            end
            bmm_pkg::ST_TGT:
            begin
                cursor_next = es_rnext;
                t_next      = es_rtarget;
                rm_raddr    = IW'(es_rtarget - VW'(1));
                state_next  = (es_rtarget > nr || es_rtarget == '0) ?
                              bmm_pkg::ST_EDGE : bmm_pkg::ST_VIS;
            end
            bmm_pkg::ST_VIS:
            begin
                rm_waddr   = IW'(t_reg - VW'(1));
                st_raddr   = SAW'(sp_reg - SW'(1));
                head_raddr = IW'(rm_partner - VW'(1));
                if (rm_tag == i_reg)
                begin
                    state_next = bmm_pkg::ST_EDGE;
                end
                else if (rm_partner == '0)
                begin
                    rm_we    = 1'b1;
                    rm_wdata = {i_reg, cur_left_reg};
                    if (sp_reg == '0)
                    begin
                        count_next = count_reg + VW'(1);
                        state_next = bmm_pkg::ST_NEXT;
                    end
                    else
                    begin
                        state_next = bmm_pkg::ST_UNWIND;
                    end
                end
                else
                begin
                    rm_we    = 1'b1;
                    rm_wdata = {i_reg, rm_partner};
                    if (sp_reg >= SP_MAX)
                    begin
                        state_next = bmm_pkg::ST_EDGE;
                    end
                    else
                    begin
                        st_we         = 1'b1;
                        sp_next       = sp_reg + SW'(1);
                        cur_left_next = rm_partner;
                        state_next    = bmm_pkg::ST_HEAD;
                    end
                end
            end
            bmm_pkg::ST_POP:
            begin
                cur_left_next = fr_left;
                cursor_next   = fr_cursor;
                sp_next       = sp_reg - SW'(1);
                state_next    = bmm_pkg::ST_EDGE;
            end
            bmm_pkg::ST_UNWIND:
            begin
                rm_we    = 1'b1;
                rm_waddr = IW'(fr_right - VW'(1));
                rm_wdata = {i_reg, fr_left};
                sp_next  = sp_reg - SW'(1);
                st_raddr = SAW'(sp_reg - SW'(2));
                if (sp_reg == SW'(1))
                begin
                    count_next = count_reg + VW'(1);
                    state_next = bmm_pkg::ST_NEXT;
                end
            end
            bmm_pkg::ST_NEXT:
            begin
                i_next     = i_reg + VW'(1);
                state_next = (i_reg == nl) ? bmm_pkg::ST_DONE : bmm_pkg::ST_START;
            end
            bmm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = bmm_pkg::FIELD_W'(count_reg);
                    out_drop_next  = ovf_reg;
                    state_next     = bmm_pkg::ST_IDLE;
                end
            end
            default: state_next = bmm_pkg::ST_IDLE;
        endcase
    end

    `BMM_ASSERT_NOW(a_sp_bound, clk, rst_n, state_reg != bmm_pkg::ST_IDLE, sp_reg <= SP_MAX, "search stack beyond its depth")
    `BMM_ASSERT_NOW(a_total_bound, clk, rst_n, 1'b1, total_reg <= E_P, "edge count beyond store size")
    `BMM_ASSERT_NEXT(a_run_sweep, clk, rst_n, cmd.valid && cmd.ready && cmd.action == bmm_pkg::ACT_RUN, state_reg == bmm_pkg::ST_RSWEEP, "run item did not start the match table sweep")
    `BMM_ASSERT_NOW(a_count_bound, clk, rst_n, state_reg == bmm_pkg::ST_DONE, count_reg <= nl, "matching larger than left side")

endmodule

### rtl/core/bmm_edge_store.sv
// Edge store: target vertex and next-edge link per edge, one write and one
// registered read per cycle. No package dependencies.
module bmm_edge_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int TW    = 10,
    parameter int NW    = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [TW-1:0] wtarget,
    input  logic [NW-1:0] wnext,
    input  logic [AW-1:0] raddr,
    output logic [TW-1:0] rtarget,
    output logic [NW-1:0] rnext
);

    logic [TW-1:0] target_mem [DEPTH];
    logic [NW-1:0] next_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            target_mem[waddr] <= wtarget;
            next_mem[waddr]   <= wnext;
        end
        rtarget <= target_mem[raddr];
        rnext   <= next_mem[raddr];
    end

endmodule

### tb/bmm_checker.sv
// Checker for the bipartite matching block: watches the command, result and
// register write ports, predicts each run's result and compares it.
// Depends on bmm_pkg and the bmm_cmd_if / bmm_rsp_if interfaces.
module bmm_checker #(
    parameter int MAX_VERTICES = 512,
    parameter int MAX_EDGES    = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bmm_cmd_if                          cmd,
    bmm_rsp_if                          rsp,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [bmm_pkg::FIELD_W-1:0] wr_data,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [bmm_pkg::FIELD_W-1:0] match_count;
        logic                        edges_dropped;
    } matching_t;

    logic [bmm_pkg::FIELD_W-1:0] edge_tgt [MAX_EDGES];
    logic [16:0]                 edge_nxt [MAX_EDGES];
    logic [16:0]                 head_of  [MAX_VERTICES+1];
    logic [bmm_pkg::FIELD_W-1:0] partner  [MAX_VERTICES+1];
    bit                          seen     [MAX_VERTICES+1];
    int                          stk_left [MAX_VERTICES+2];
    int                          stk_cur  [MAX_VERTICES+2];
    int                          stk_right[MAX_VERTICES+2];
    int                          n_edges;
    bit                          dropped;
    logic [bmm_pkg::FIELD_W-1:0] left_reg;
    logic [bmm_pkg::FIELD_W-1:0] right_reg;
    matching_t                   expected_q[$];

    function automatic bit try_augment(int root, int rlimit);
        int depth;
        int p;
        int t;
        int owner;
        depth = 1;
        stk_left[0] = root;
        stk_cur[0] = head_of[root];
        stk_right[0] = 0;
        while (depth > 0) begin
            p = stk_cur[depth-1];
            if (p == 0 || p > MAX_EDGES) begin
                depth--;
                continue;
            end
            stk_cur[depth-1] = edge_nxt[p-1];
            t = edge_tgt[p-1];
            if (t == 0 || t > rlimit || seen[t])
                continue;
            seen[t] = 1;
            owner = partner[t];
            if (owner == 0) begin
                partner[t] = bmm_pkg::FIELD_W'(stk_left[depth-1]);
                for (int k = depth - 1; k > 0; k--)
                    partner[stk_right[k-1]] = bmm_pkg::FIELD_W'(stk_left[k-1]);
                return 1;
            end
            if (owner > MAX_VERTICES || depth >= MAX_VERTICES + 2)
                continue;
            stk_right[depth-1] = t;
            stk_left[depth] = owner;
            stk_cur[depth] = head_of[owner];
            stk_right[depth] = 0;
            depth++;
        end
        return 0;
    endfunction

    function automatic matching_t max_matching();
        matching_t r;
        int nl;
        int nr;
        int found;
        nl = (left_reg > MAX_VERTICES) ? MAX_VERTICES : left_reg;
        nr = (right_reg > MAX_VERTICES) ? MAX_VERTICES : right_reg;
        found = 0;
        foreach (partner[i]) partner[i] = '0;
        for (int i = 1; i <= nl; i++) begin
            foreach (seen[j]) seen[j] = 0;
            if (try_augment(i, nr))
                found++;
        end
        r.match_count = found[bmm_pkg::FIELD_W-1:0];
        r.edges_dropped = dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        matching_t got;
        matching_t want;
        int u;
        int v;
        if (!rst_n) begin
            foreach (head_of[i]) head_of[i] = '0;
            n_edges = 0;
            dropped = 0;
            left_reg = bmm_pkg::FIELD_W'(1);
            right_reg = bmm_pkg::FIELD_W'(1);
            fail_count = 0;
            expected_q.delete();
            pending = 0;
        end else begin
            if (wr_en) begin
                if (wr_index == bmm_pkg::REG_LEFT_COUNT)
                    left_reg = wr_data;
                else
                    right_reg = wr_data;
            end
            if (rsp.valid && rsp.ready) begin
                got.match_count = rsp.match_count;
                got.edges_dropped = rsp.edges_dropped;
                if (expected_q.size() == 0) begin
                    $error("unexpected result item: match_count %0d", got.match_count);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.match_count !== want.match_count) begin
                        $error("match_count: expected %0d, actual %0d",
                               want.match_count, got.match_count);
                        fail_count++;
                    end
                    if (got.edges_dropped !== want.edges_dropped) begin
                        $error("edges_dropped: expected %0d, actual %0d",
                               want.edges_dropped, got.edges_dropped);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready) begin
                u = cmd.left_vertex;
                v = cmd.right_vertex;
                case (cmd.action)
                    bmm_pkg::ACT_ADD: begin
                        if (u != 0 && u <= MAX_VERTICES && v != 0 && v <= MAX_VERTICES) begin
                            if (n_edges >= MAX_EDGES) begin
                                dropped = 1;
                            end else begin
                                edge_tgt[n_edges] = bmm_pkg::FIELD_W'(v);
                                edge_nxt[n_edges] = head_of[u];
                                n_edges++;
                                head_of[u] = 17'(n_edges);
                            end
                        end
                    end
                    bmm_pkg::ACT_RUN: expected_q.push_back(max_matching());
                    bmm_pkg::ACT_CLEAR: begin
                        foreach (head_of[i]) head_of[i] = '0;
                        n_edges = 0;
                        dropped = 0;
                    end
                    default: ;
                endcase
            end
            pending = expected_q.size();
        end
    end
endmodule

### tb/tb_top.sv
// Testbench top for the bipartite matching block: clock, reset, command and
// register stimulus, result-side stalls, watchdog and verdict.
// Depends on bmm_pkg, bmm_if, bmm_checker and the block itself.
module tb_top;

    localparam int SETTLE = 700;
    localparam int IDLE_LIMIT = 300000;

    logic                        clk;
    logic                        rst_n;
    logic                        wr_en;
    logic                        wr_index;
    logic [bmm_pkg::FIELD_W-1:0] wr_data;
    int                          fail_count;
    int                          pending;
    int                          send_gap_pct;
    int                          stall_pct;
    bit                          hold_req;
    bit                          hold_taken;
    int                          hold_left;
    int                          idle_cycles;
    int                          item_total;
    int                          cur_left;
    int                          cur_right;

    bmm_cmd_if cmd ();
    bmm_rsp_if rsp ();

    bipartite_max_matching_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rsp      (rsp),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    bmm_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rsp.ready = 1'b0;
        hold_left = 0;
        hold_taken = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_left = 3000;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(logic [1:0] act, int u, int v);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_gap_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.action <= act;
        cmd.left_vertex <= u[bmm_pkg::FIELD_W-1:0];
        cmd.right_vertex <= v[bmm_pkg::FIELD_W-1:0];
        do
            @(posedge clk);
        while (!cmd.ready);
        @(negedge clk);
        if (act != bmm_pkg::ACT_UNUSED &&
            !(act == bmm_pkg::ACT_ADD && (u == 0 || u > 512 || v == 0 || v > 512)))
            item_total++;
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_counts(int l, int r);
        drain();
        wr_en <= 1'b1;
        wr_index <= bmm_pkg::REG_LEFT_COUNT;
        wr_data <= l[bmm_pkg::FIELD_W-1:0];
        @(negedge clk);
        wr_index <= bmm_pkg::REG_RIGHT_COUNT;
        wr_data <= r[bmm_pkg::FIELD_W-1:0];
        @(negedge clk);
        wr_en <= 1'b0;
        cur_left = l;
        cur_right = r;
    endtask

    function automatic int pick_count();
        int k;
        k = $urandom_range(99);
        if (k < 4)
            return 512;
        if (k < 7)
            return $urandom_range(513, 1023);
        if (k < 9)
            return 0;
        if (k < 12)
            return $urandom_range(1, 512);
        return $urandom_range(1, 12);
    endfunction

    function automatic int pick_vertex(int lim);
        int top;
        top = (lim < 1 || lim > 14) ? 14 : lim + 2;
        if ($urandom_range(19) == 0)
            return $urandom_range(1, 512);
        return $urandom_range(1, top);
    endfunction

    task automatic random_graph();
        int n;
        int k;
        send_item(bmm_pkg::ACT_CLEAR, $urandom_range(1023), $urandom_range(1023));
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 85)
                send_item(bmm_pkg::ACT_ADD, pick_vertex(cur_left), pick_vertex(cur_right));
            else if (k < 90)
                send_item(bmm_pkg::ACT_ADD, $urandom_range(1023), 0);
            else if (k < 93)
                send_item(bmm_pkg::ACT_ADD, $urandom_range(513, 1023), $urandom_range(1023));
            else if (k < 96)
                send_item(bmm_pkg::ACT_UNUSED, $urandom_range(1023), $urandom_range(1023));
            else
                send_item(bmm_pkg::ACT_RUN, $urandom_range(1023), $urandom_range(1023));
        end
        send_item(bmm_pkg::ACT_RUN, $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic random_phase(int gap_pct, int stall, int quota);
        int goal;
        send_gap_pct = gap_pct;
        stall_pct = stall;
        goal = item_total + quota;
        while (item_total < goal)
        begin
            if ($urandom_range(3) == 0)
                write_counts(pick_count(), pick_count());
            random_graph();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = 1'b0;
        wr_data = '0;
        cmd.valid = 1'b0;
        cmd.action = bmm_pkg::ACT_ADD;
        cmd.left_vertex = '0;
        cmd.right_vertex = '0;
        send_gap_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        idle_cycles = 0;
        item_total = 0;
        cur_left = 1;
        cur_right = 1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send_item(bmm_pkg::ACT_ADD, 1, 1);
        send_item(bmm_pkg::ACT_RUN, 0, 0);
        write_counts(3, 3);
        send_item(bmm_pkg::ACT_ADD, 1, 1);
        send_item(bmm_pkg::ACT_ADD, 1, 2);
        send_item(bmm_pkg::ACT_ADD, 2, 1);
        send_item(bmm_pkg::ACT_ADD, 3, 3);
        send_item(bmm_pkg::ACT_ADD, 3, 4);
        send_item(bmm_pkg::ACT_ADD, 512, 512);
        send_item(bmm_pkg::ACT_ADD, 0, 5);
        send_item(bmm_pkg::ACT_ADD, 5, 0);
        send_item(bmm_pkg::ACT_ADD, 513, 1);
        send_item(bmm_pkg::ACT_ADD, 1, 1023);
        send_item(bmm_pkg::ACT_UNUSED, 1023, 1023);
        send_item(bmm_pkg::ACT_RUN, 1023, 1023);
        write_counts(1023, 1023);
        send_item(bmm_pkg::ACT_RUN, 0, 0);
        write_counts(512, 512);
        send_item(bmm_pkg::ACT_RUN, 0, 0);
        write_counts(0, 5);
        send_item(bmm_pkg::ACT_RUN, 0, 0);
        write_counts(5, 0);
        send_item(bmm_pkg::ACT_RUN, 0, 0);
        send_item(bmm_pkg::ACT_CLEAR, 0, 0);
        send_item(bmm_pkg::ACT_RUN, 0, 0);

        random_phase(0, 0, 480);
        random_phase(76, 0, 480);

        // Long receiver hold-off while runs keep arriving.
        drain();
        hold_req = 1;
        for (int i = 0; i < 5; i++)
            send_item(bmm_pkg::ACT_RUN, 0, 0);
        hold_req = 0;

        random_phase(0, 76, 480);
        random_phase(25, 25, 480);

        drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
